// ----- hw/rtl/bbsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bbsr_pkg
// Shared constants for the bad-block sparing table: default geometry,
// field widths, item modes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bbsr_pkg;

  // default device geometry
  localparam int DefBlocks = 32;
  localparam int DefSpares = 8;

  // fixed field widths
  localparam int BlockNumW = 6;
  localparam int PhysW     = 5;
  localparam int StatusW   = 3;

  typedef logic [StatusW-1:0] status_t;
  typedef logic [PhysW-1:0]   phys_t;

  // item modes
  localparam logic ModeMark   = 1'b0;
  localparam logic ModeAccess = 1'b1;

  // result status codes
  localparam status_t StatusDirect   = 3'd0;
  localparam status_t StatusRemap    = 3'd1;
  localparam status_t StatusAssigned = 3'd2;
  localparam status_t StatusFull     = 3'd3;
  localparam status_t StatusInvalid  = 3'd4;

endpackage

`default_nettype wire

// ----- hw/rtl/bbsr_ram.sv -----
// ----------------------------------------------------------------------------
// bbsr_ram
// Generic single-clock RAM, one write port and one read port, with the
// read data registered (held when not reading).
// ----------------------------------------------------------------------------
`default_nettype none

module bbsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bad_block_spare_remap.sv -----
// ----------------------------------------------------------------------------
// bad_block_spare_remap
// Bad-block sparing table: the last Spares blocks of the device are spares,
// bad blocks are recorded in slot order and accesses are redirected.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries mode_i and
//   block_number_i. Mode mark records the block in the next free slot and
//   answers with that slot's spare (full status if none is left); access
//   looks the block up and answers with its spare, or the block on a miss.
//   Output channel (out_valid_o / out_ready_i) carries status_o and
//   physical_block_o, one result item per input item, in order.
//   Latency: a mark, an invalid block, or an access with an empty table
//   gives its result one cycle after acceptance, and the next item may be
//   taken in the following cycle. An access scans the filled slots through
//   the single read port of the slot RAM, one slot per cycle while the
//   output register is empty or being drained, and ends at the matching
//   slot or, on a miss, after the last filled slot.
//   Reset clears the state, fill count and output valid flag; the slot RAM
//   needs no clearing since only filled slots are ever read.
//   A stalled receiver holds the result in the output register; a new item
//   is taken when no scan is running and that register is empty or being
//   drained.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_block_spare_remap #(
  parameter int Blocks = bbsr_pkg::DefBlocks,
  parameter int Spares = bbsr_pkg::DefSpares
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           mode_i,
  input  wire logic [bbsr_pkg::BlockNumW-1:0] block_number_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bbsr_pkg::status_t                   status_o,
  output bbsr_pkg::phys_t                     physical_block_o
);

  localparam int EntryW = $clog2(Blocks);
  localparam int SlotW  = (Spares > 1) ? $clog2(Spares) : 1;
  localparam int CntW   = $clog2(Spares + 1);
  localparam int SpareBaseInt = Blocks - Spares;
  localparam logic [bbsr_pkg::PhysW-1:0] SpareBase = bbsr_pkg::PhysW'(SpareBaseInt);

  // controller states
  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic                           state_q, state_d;
  logic [CntW-1:0]                used_q, used_d;
  logic [SlotW-1:0]               idx_q, idx_d;
  logic [bbsr_pkg::BlockNumW-1:0] blk_q, blk_d;
  logic                           out_valid_q, out_valid_d;
  bbsr_pkg::status_t              status_q, status_d;
  bbsr_pkg::phys_t                phys_q, phys_d;

  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [SlotW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  logic out_free;
  logic in_fire;
  logic blk_invalid;
  logic table_full;
  logic scan_last;

  // spare block number of a slot, masked to the output width
  function automatic bbsr_pkg::phys_t spare_of(input logic [SlotW-1:0] slot);
    spare_of = SpareBase + bbsr_pkg::PhysW'(slot);
  endfunction

  // slot table
  bbsr_ram #(
    .Width (EntryW),
    .Depth (Spares)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshake and item checks
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign blk_invalid = {1'b0, block_number_i} >= (bbsr_pkg::BlockNumW + 1)'(Blocks);
  assign table_full  = used_q == CntW'(Spares);
  assign scan_last   = (CntW'(idx_q) + CntW'(1)) == used_q;

  // mark, lookup scan and result register control
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    idx_d       = idx_q;
    blk_d       = blk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    phys_d      = phys_q;
    ram_we      = 1'b0;
    ram_waddr   = used_q[SlotW-1:0];
    ram_wdata   = block_number_i[EntryW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          blk_d = block_number_i;
          if (blk_invalid) begin
            out_valid_d = 1'b1;
            status_d    = bbsr_pkg::StatusInvalid;
            phys_d      = '0;
          end else if (mode_i == bbsr_pkg::ModeMark) begin
            out_valid_d = 1'b1;
            if (table_full) begin
              status_d = bbsr_pkg::StatusFull;
              phys_d   = '0;
            end else begin
              ram_we   = 1'b1;
              status_d = bbsr_pkg::StatusAssigned;
              phys_d   = spare_of(used_q[SlotW-1:0]);
              used_d   = used_q + CntW'(1);
            end
          end else if (used_q == '0) begin
            out_valid_d = 1'b1;
            status_d    = bbsr_pkg::StatusDirect;
            phys_d      = block_number_i[bbsr_pkg::PhysW-1:0];
          end else begin
            // start the scan at the first slot
            ram_re  = 1'b1;
            idx_d   = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        // read data holds while the result register is occupied
        if (out_free) begin
          if (ram_rdata == blk_q[EntryW-1:0]) begin
            out_valid_d = 1'b1;
            status_d    = bbsr_pkg::StatusRemap;
            phys_d      = spare_of(idx_q);
            state_d     = StIdle;
          end else if (scan_last) begin
            out_valid_d = 1'b1;
            status_d    = bbsr_pkg::StatusDirect;
            phys_d      = blk_q[bbsr_pkg::PhysW-1:0];
            state_d     = StIdle;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + SlotW'(1);
            idx_d     = idx_q + SlotW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    blk_q    <= blk_d;
    status_q <= status_d;
    phys_q   <= phys_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign physical_block_o = phys_q;

endmodule

`default_nettype wire
